// File: rtl/core/fqp_pkg.sv
// fqp_pkg: types, codes and character constants shared by the FASTQ record parser.
// Used by fqp_parser and fastq_record_parser_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fqp_pkg;

    // default width of the internal length counters
    localparam int LENGTH_BITS_DEFAULT = 16;
    // reported length fields are fixed at 16 bits
    localparam int LEN_OUT_W = 16;

    typedef enum logic [2:0] {
        PH_BETWEEN    = 3'd0,
        PH_HEADER     = 3'd1,
        PH_SEQ        = 3'd2,
        PH_PLUS_START = 3'd3,
        PH_PLUS_BODY  = 3'd4,
        PH_QUAL       = 3'd5
    } phase_t;

    localparam logic [2:0] CLS_ID      = 3'd0;
    localparam logic [2:0] CLS_COMMENT = 3'd1;
    localparam logic [2:0] CLS_SEQ     = 3'd2;
    localparam logic [2:0] CLS_PLUS    = 3'd3;
    localparam logic [2:0] CLS_QUAL    = 3'd4;
    localparam logic [2:0] CLS_MARK    = 3'd5;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NO_AT      = 4'd1;
    localparam logic [3:0] ERR_NO_PLUS    = 4'd2;
    localparam logic [3:0] ERR_TRUNC_HDR  = 4'd3;
    localparam logic [3:0] ERR_TRUNC_SEQ  = 4'd4;
    localparam logic [3:0] ERR_TRUNC_PLUS = 4'd5;
    localparam logic [3:0] ERR_TRUNC_QUAL = 4'd6;
    localparam logic [3:0] ERR_EMPTY_SEQ  = 4'd7;
    localparam logic [3:0] ERR_LEN_MISM   = 4'd8;
    localparam logic [3:0] ERR_OVERLONG   = 4'd9;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AT    = 8'h40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic [2:0]           byte_class;
        logic                 cr_before;
        logic                 record_done;
        logic [LEN_OUT_W-1:0] id_length;
        logic [LEN_OUT_W-1:0] comment_length;
        logic [LEN_OUT_W-1:0] seq_length;
        logic [3:0]           error_code;
    } out_t;

endpackage

`default_nettype wire

// File: rtl/core/fqp_parser.sv
// fqp_parser: parse state registers and the per-word classification logic.
// Depends on fqp_pkg; the result is combinational from the current word and state.
`timescale 1ns / 1ps
`default_nettype none

module fqp_parser #(
    parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire fqp_pkg::in_t item,
    input  wire logic         step_en,
    output fqp_pkg::out_t     result
);

    typedef struct packed {
        logic [LENGTH_BITS-1:0] id;
        logic [LENGTH_BITS-1:0] com;
        logic [LENGTH_BITS-1:0] seq;
        logic [LENGTH_BITS-1:0] qual;
    } counts_t;

    typedef struct packed {
        logic    ok;
        counts_t c;
    } bump_t;

    // count one data byte in the field of the given phase; ok drops on overflow
    function automatic bump_t count_field(input fqp_pkg::phase_t ph, input logic ic,
                                          input counts_t c);
        bump_t r;
        r.ok = 1'b1;
        r.c  = c;
        case (ph)
            fqp_pkg::PH_HEADER: begin
                if (ic) begin
                    if (&c.com) r.ok = 1'b0;
                    else        r.c.com = c.com + LENGTH_BITS'(1);
                end else begin
                    if (&c.id) r.ok = 1'b0;
                    else       r.c.id = c.id + LENGTH_BITS'(1);
                end
            end
            fqp_pkg::PH_SEQ: begin
                if (&c.seq) r.ok = 1'b0;
                else        r.c.seq = c.seq + LENGTH_BITS'(1);
            end
            fqp_pkg::PH_QUAL: begin
                if (&c.qual) r.ok = 1'b0;
                else         r.c.qual = c.qual + LENGTH_BITS'(1);
            end
            default: ;
        endcase
        return r;
    endfunction

    fqp_pkg::phase_t phase_reg, phase_next;
    logic            held_cr_reg, held_cr_next;
    logic            in_comment_reg, in_comment_next;
    counts_t         counts_reg, counts_next;
    logic [3:0]      err_reg, err_next;

    always_comb begin
        logic [7:0] b;
        logic       eos;
        logic       ok;
        logic       done;
        logic       crb;
        logic [2:0] cls;
        bump_t      bres;

        b    = item.data_byte;
        eos  = item.end_of_stream;
        ok   = 1'b1;
        done = 1'b0;
        crb  = 1'b0;
        cls  = fqp_pkg::CLS_MARK;
        bres = '0;

        phase_next      = phase_reg;
        held_cr_next    = held_cr_reg;
        in_comment_next = in_comment_reg;
        counts_next     = counts_reg;
        err_next        = err_reg;

        if (err_reg == fqp_pkg::ERR_NONE) begin
            if (eos) begin
                case (phase_reg)
                    fqp_pkg::PH_HEADER:     err_next = fqp_pkg::ERR_TRUNC_HDR;
                    fqp_pkg::PH_SEQ:        err_next = fqp_pkg::ERR_TRUNC_SEQ;
                    fqp_pkg::PH_PLUS_START: err_next = fqp_pkg::ERR_TRUNC_PLUS;
                    fqp_pkg::PH_PLUS_BODY:  err_next = fqp_pkg::ERR_TRUNC_PLUS;
                    fqp_pkg::PH_QUAL: begin
                        if (counts_reg.qual == '0 && !held_cr_reg)
                            err_next = fqp_pkg::ERR_TRUNC_QUAL;
                        else if (counts_reg.seq == '0)
                            err_next = fqp_pkg::ERR_EMPTY_SEQ;
                        else if (counts_reg.seq != counts_reg.qual)
                            err_next = fqp_pkg::ERR_LEN_MISM;
                        else
                            done = 1'b1;
                    end
                    default: ;
                endcase
            end else begin
                // a held cr not followed by lf is a data byte of its field
                if (held_cr_reg) begin
                    held_cr_next = 1'b0;
                    if (b != fqp_pkg::CH_LF) begin
                        crb  = 1'b1;
                        bres = count_field(phase_reg, in_comment_reg, counts_next);
                        ok   = bres.ok;
                        if (bres.ok) counts_next = bres.c;
                        else         err_next = fqp_pkg::ERR_OVERLONG;
                    end
                end
                if (ok) begin
                    case (phase_reg)
                        fqp_pkg::PH_BETWEEN: begin
                            if (b == fqp_pkg::CH_LF || b == fqp_pkg::CH_CR) begin
                                phase_next = phase_reg;
                            end else if (b == fqp_pkg::CH_AT) begin
                                phase_next      = fqp_pkg::PH_HEADER;
                                in_comment_next = 1'b0;
                            end else begin
                                err_next = fqp_pkg::ERR_NO_AT;
                            end
                        end
                        fqp_pkg::PH_HEADER: begin
                            if (b == fqp_pkg::CH_LF) begin
                                phase_next = fqp_pkg::PH_SEQ;
                            end else if (b == fqp_pkg::CH_CR) begin
                                held_cr_next = 1'b1;
                            end else if (!in_comment_reg &&
                                         (b == fqp_pkg::CH_SPACE || b == fqp_pkg::CH_TAB)) begin
                                in_comment_next = 1'b1;
                            end else begin
                                bres = count_field(phase_reg, in_comment_reg, counts_next);
                                if (bres.ok) begin
                                    counts_next = bres.c;
                                    cls = in_comment_reg ? fqp_pkg::CLS_COMMENT
                                                         : fqp_pkg::CLS_ID;
                                end else begin
                                    err_next = fqp_pkg::ERR_OVERLONG;
                                end
                            end
                        end
                        fqp_pkg::PH_SEQ: begin
                            if (b == fqp_pkg::CH_LF) begin
                                phase_next = fqp_pkg::PH_PLUS_START;
                            end else if (b == fqp_pkg::CH_CR) begin
                                held_cr_next = 1'b1;
                            end else begin
                                bres = count_field(phase_reg, in_comment_reg, counts_next);
                                if (bres.ok) begin
                                    counts_next = bres.c;
                                    cls = fqp_pkg::CLS_SEQ;
                                end else begin
                                    err_next = fqp_pkg::ERR_OVERLONG;
                                end
                            end
                        end
                        fqp_pkg::PH_PLUS_START: begin
                            if (b == fqp_pkg::CH_PLUS) begin
                                phase_next = fqp_pkg::PH_PLUS_BODY;
                                cls = fqp_pkg::CLS_PLUS;
                            end else begin
                                err_next = fqp_pkg::ERR_NO_PLUS;
                            end
                        end
                        fqp_pkg::PH_PLUS_BODY: begin
                            if (b == fqp_pkg::CH_LF)      phase_next = fqp_pkg::PH_QUAL;
                            else if (b == fqp_pkg::CH_CR) held_cr_next = 1'b1;
                            else                          cls = fqp_pkg::CLS_PLUS;
                        end
                        fqp_pkg::PH_QUAL: begin
                            if (b == fqp_pkg::CH_LF) begin
                                if (counts_next.seq == '0)
                                    err_next = fqp_pkg::ERR_EMPTY_SEQ;
                                else if (counts_next.seq != counts_next.qual)
                                    err_next = fqp_pkg::ERR_LEN_MISM;
                                else
                                    done = 1'b1;
                            end else if (b == fqp_pkg::CH_CR) begin
                                held_cr_next = 1'b1;
                            end else begin
                                bres = count_field(phase_reg, in_comment_reg, counts_next);
                                if (bres.ok) begin
                                    counts_next = bres.c;
                                    cls = fqp_pkg::CLS_QUAL;
                                end else begin
                                    err_next = fqp_pkg::ERR_OVERLONG;
                                end
                            end
                        end
                        default: phase_next = fqp_pkg::PH_BETWEEN;
                    endcase
                end
            end
        end

        result.out_byte       = eos ? 8'd0 : b;
        result.byte_class     = cls;
        result.cr_before      = crb;
        result.record_done    = done;
        result.id_length      = '0;
        result.comment_length = '0;
        result.seq_length     = '0;
        result.error_code     = err_next;

        if (err_next == fqp_pkg::ERR_NONE) begin
            if (done) begin
                result.id_length      = fqp_pkg::LEN_OUT_W'(counts_next.id);
                result.comment_length = fqp_pkg::LEN_OUT_W'(counts_next.com);
                result.seq_length     = fqp_pkg::LEN_OUT_W'(counts_next.seq);
            end
            // record closed or stream ended: back between records
            if (done || eos) begin
                phase_next      = fqp_pkg::PH_BETWEEN;
                held_cr_next    = 1'b0;
                in_comment_next = 1'b0;
                counts_next     = '0;
            end
        end else begin
            result.byte_class  = fqp_pkg::CLS_MARK;
            result.cr_before   = 1'b0;
            result.record_done = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fqp_pkg::PH_BETWEEN;
            held_cr_reg    <= 1'b0;
            in_comment_reg <= 1'b0;
            counts_reg     <= '0;
            err_reg        <= fqp_pkg::ERR_NONE;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            held_cr_reg    <= held_cr_next;
            in_comment_reg <= in_comment_next;
            counts_reg     <= counts_next;
            err_reg        <= err_next;
        end
    end

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != fqp_pkg::ERR_NONE |=> $stable(err_reg))
        else $error("sticky error code changed");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        result.record_done |-> (result.error_code == fqp_pkg::ERR_NONE &&
                                phase_next == fqp_pkg::PH_BETWEEN))
        else $error("record done with error or open record");

    a_between_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg == fqp_pkg::ERR_NONE && phase_reg == fqp_pkg::PH_BETWEEN) |->
        (counts_reg == '0 && !held_cr_reg && !in_comment_reg))
        else $error("stale record state between records");

    a_cr_held: assert property (@(posedge aclk) disable iff (!aresetn)
        result.cr_before |-> held_cr_reg)
        else $error("cr_before without a held cr");

endmodule

`default_nettype wire

// File: rtl/core/fastq_record_parser_top.sv
// FASTQ record parser top: one byte per cycle unless m_ready stalls, tags each
// byte with its field. Takes one input word per clock while not stalled and
// delivers one result word per input word, via the input register, then the
// result register. The parse step between the two registers is combinational,
// and s_ready follows m_ready combinationally through both stages.
// Errors are sticky until aresetn. No clearing pass is needed after reset.
// Depends on fqp_pkg and fqp_parser.
`timescale 1ns / 1ps
`default_nettype none

module fastq_record_parser_top #(
    parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fqp_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output fqp_pkg::out_t      m_data
);

    logic          in_valid_reg, in_valid_next;
    fqp_pkg::in_t  in_data_reg;
    logic          out_valid_reg, out_valid_next;
    fqp_pkg::out_t out_data_reg;
    fqp_pkg::out_t step_result;
    logic          adv;

    // input word moves on when the result register is empty or draining
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    fqp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_data_reg),
        .step_en (adv),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (adv)                out_data_reg <= step_result;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_adv_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid)
        else $error("advanced word did not reach the result register");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("held input word lost or changed");

endmodule

`default_nettype wire
